FILE: design/rlrb_pkg.sv
`default_nettype none
package rlrb_pkg;

   localparam logic [2:0] MODE_OPEN   = 3'd0;
   localparam logic [2:0] MODE_APPEND = 3'd1;
   localparam logic [2:0] MODE_CLEAR  = 3'd2;
   localparam logic [2:0] MODE_FWD    = 3'd3;
   localparam logic [2:0] MODE_BWD    = 3'd4;
   localparam logic [2:0] MODE_READ   = 3'd5;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_TOO_LONG  = 2'd1;
   localparam logic [1:0] ST_NO_RECORD = 2'd2;
   localparam logic [1:0] ST_NO_SCAN   = 2'd3;

   typedef enum logic [1:0] {
      SCAN_IDLE = 2'd0,
      SCAN_FWD  = 2'd1,
      SCAN_BWD  = 2'd2,
      SCAN_DONE = 2'd3
   } scan_state_type;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_LOAD,
      OP_SET_ST,
      OP_OPEN,
      OP_HDR_WR,
      OP_TRL_WR,
      OP_COMMIT,
      OP_APPEND,
      OP_CLEAR,
      OP_WALK_INIT,
      OP_WALK_STEP,
      OP_WALK_END,
      OP_BWD_INIT,
      OP_WORD_START,
      OP_WORD_RD,
      OP_WORD_CAP,
      OP_FWD_HDR,
      OP_BWD_HDR,
      OP_BYTE_RD,
      OP_BYTE_TAKE,
      OP_EMPTY_REC,
      OP_SET_DONE,
      OP_SD_ONLY,
      OP_RSP_LOAD
   } dp_op_type;

   typedef enum logic [1:0] {
      BASE_WALK,
      BASE_SPTR,
      BASE_SNEXT
   } base_sel_type;

   typedef struct packed {
      logic [2:0]  mode;
      logic [11:0] record_length;
      logic [7:0]  data_byte;
      logic [9:0]  max_records;
   } rlrb_req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [7:0] read_byte;
      logic       byte_valid;
      logic       record_end;
      logic       scan_done;
      logic       is_empty;
   } rlrb_rsp_type;

   typedef struct packed {
      dp_op_type    op;
      base_sel_type base;
      logic [1:0]   st;
   } dp_cmd_type;

   typedef struct packed {
      logic [2:0]     mode;
      logic           too_long;
      logic           open;
      logic           remain_one;
      logic           len_zero;
      logic           idx_last;
      logic           walk_room;
      logic           walk_bad;
      logic           walk_limit;
      scan_state_type sstate;
      logic           fresh;
      logic           srec_zero;
      logic           bwd_blocked;
      logic           bwd_bad;
      logic           left_zero;
      logic           rsp_free;
   } dp_status_type;

endpackage
`default_nettype wire

FILE: design/rlrb_ctrl.sv
`default_nettype none
module rlrb_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire rlrb_pkg::dp_status_type status,
   output rlrb_pkg::dp_cmd_type         cmd
);
   import rlrb_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_DECODE, S_HDR, S_TRL, S_COMMIT, S_WALK, S_WRD, S_WCAP,
      S_WEVAL, S_WEND, S_FHDR, S_BHDR, S_BYTE, S_BTAKE, S_FINISH
   } state_type;

   typedef enum logic [1:0] {R_WALK, R_FHDR, R_BHDR} ret_type;

   state_type state_ff, state_in;
   ret_type   ret_ff, ret_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      cmd      = '{op: OP_NONE, base: BASE_WALK, st: ST_OK};
      state_in = state_ff;
      ret_in   = ret_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            state_in = S_FINISH;
            unique case (status.mode)
               MODE_OPEN: begin
                  if (status.too_long) begin
                     cmd.op = OP_SET_ST;
                     cmd.st = ST_TOO_LONG;
                  end else begin
                     cmd.op   = OP_OPEN;
                     state_in = S_HDR;
                  end
               end
               MODE_APPEND: begin
                  if (!status.open) begin
                     cmd.op = OP_SET_ST;
                     cmd.st = ST_NO_RECORD;
                  end else begin
                     cmd.op = OP_APPEND;
                     if (status.remain_one) state_in = S_TRL;
                  end
               end
               MODE_CLEAR: cmd.op = OP_CLEAR;
               MODE_FWD: begin
                  cmd.op   = OP_WALK_INIT;
                  state_in = S_WALK;
               end
               MODE_BWD: cmd.op = OP_BWD_INIT;
               MODE_READ: begin
                  unique case (status.sstate)
                     SCAN_IDLE: begin
                        cmd.op = OP_SET_ST;
                        cmd.st = ST_NO_SCAN;
                     end
                     SCAN_DONE: cmd.op = OP_SD_ONLY;
                     SCAN_FWD: begin
                        if (!status.fresh) begin
                           state_in = S_BYTE;
                        end else if (status.srec_zero) begin
                           cmd.op = OP_SET_DONE;
                        end else begin
                           cmd.op   = OP_WORD_START;
                           cmd.base = BASE_SPTR;
                           ret_in   = R_FHDR;
                           state_in = S_WRD;
                        end
                     end
                     SCAN_BWD: begin
                        if (!status.fresh) begin
                           state_in = S_BYTE;
                        end else if (status.bwd_blocked) begin
                           cmd.op = OP_SET_DONE;
                        end else begin
                           cmd.op   = OP_WORD_START;
                           cmd.base = BASE_SNEXT;
                           ret_in   = R_BHDR;
                           state_in = S_WRD;
                        end
                     end
                  endcase
               end
               default: cmd.op = OP_NONE;
            endcase
         end
         S_HDR: begin
            cmd.op = OP_HDR_WR;
            if (status.idx_last) state_in = status.len_zero ? S_TRL : S_FINISH;
         end
         S_TRL: begin
            cmd.op = OP_TRL_WR;
            if (status.idx_last) state_in = S_COMMIT;
         end
         S_COMMIT: begin
            cmd.op   = OP_COMMIT;
            state_in = S_FINISH;
         end
         S_WALK: begin
            if (!status.walk_room) begin
               cmd.op   = OP_WALK_END;
               state_in = S_FINISH;
            end else begin
               cmd.op   = OP_WORD_START;
               cmd.base = BASE_WALK;
               ret_in   = R_WALK;
               state_in = S_WRD;
            end
         end
         S_WRD: begin
            cmd.op   = OP_WORD_RD;
            state_in = S_WCAP;
         end
         S_WCAP: begin
            cmd.op   = OP_WORD_CAP;
            state_in = S_WRD;
            if (status.idx_last) begin
               unique case (ret_ff)
                  R_WALK:  state_in = S_WEVAL;
                  R_FHDR:  state_in = S_FHDR;
                  R_BHDR:  state_in = S_BHDR;
                  default: state_in = S_WEVAL;
               endcase
            end
         end
         S_WEVAL: begin
            if (status.walk_bad) begin
               cmd.op   = OP_WALK_END;
               state_in = S_FINISH;
            end else begin
               cmd.op   = OP_WALK_STEP;
               state_in = status.walk_limit ? S_WEND : S_WALK;
            end
         end
         S_WEND: begin
            cmd.op   = OP_WALK_END;
            state_in = S_FINISH;
         end
         S_FHDR: begin
            cmd.op   = OP_FWD_HDR;
            state_in = S_BYTE;
         end
         S_BHDR: begin
            if (status.bwd_bad) begin
               cmd.op   = OP_SET_DONE;
               state_in = S_FINISH;
            end else begin
               cmd.op   = OP_BWD_HDR;
               state_in = S_BYTE;
            end
         end
         S_BYTE: begin
            if (status.left_zero) begin
               cmd.op   = OP_EMPTY_REC;
               state_in = S_FINISH;
            end else begin
               cmd.op   = OP_BYTE_RD;
               state_in = S_BTAKE;
            end
         end
         S_BTAKE: begin
            cmd.op   = OP_BYTE_TAKE;
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (status.rsp_free) begin
               cmd.op   = OP_RSP_LOAD;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ret_ff   <= R_WALK;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
      end
   end

endmodule
`default_nettype wire

FILE: design/rlrb_datapath.sv
`default_nettype none
module rlrb_datapath #(
   parameter int BUFFER_BYTES      = 4096,
   parameter int LENGTH_WORD_BYTES = 4
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire rlrb_pkg::rlrb_req_type req_payload,
   input  wire rlrb_pkg::dp_cmd_type   cmd,
   output rlrb_pkg::dp_status_type      status,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output rlrb_pkg::rlrb_rsp_type       rsp_payload
);
   import rlrb_pkg::*;

   localparam int W  = LENGTH_WORD_BYTES;
   localparam int AW = $clog2(BUFFER_BYTES) + 3;
   localparam int MW = $clog2(BUFFER_BYTES);
   localparam int WB = 8 * W;
   localparam int CW = (AW > WB) ? AW : WB;
   localparam int IW = (W > 1) ? $clog2(W) : 1;

   localparam logic [AW-1:0] B1  = AW'(BUFFER_BYTES);
   localparam logic [AW-1:0] B2  = AW'(2 * BUFFER_BYTES);
   localparam logic [AW-1:0] B3  = AW'(3 * BUFFER_BYTES);
   localparam logic [AW-1:0] WA  = AW'(W);
   localparam logic [AW-1:0] W2A = AW'(2 * W);
   localparam logic [IW-1:0] IDX_LAST = IW'(W - 1);

   function automatic logic [MW-1:0] slot_of(input logic [AW-1:0] a);
      logic [AW-1:0] r;
      if (a >= B3) r = a - B3;
      else if (a >= B2) r = a - B2;
      else if (a >= B1) r = a - B1;
      else r = a;
      return r[MW-1:0];
   endfunction

   function automatic logic [AW-1:0] raise_low(input logic [AW-1:0] e,
                                               input logic [AW-1:0] ov);
      if (e >= B1 && ov < e - B1) return e - B1;
      else return ov;
   endfunction

   rlrb_req_type   req_ff, req_in;
   logic [AW-1:0]  newest_ff, newest_in, oldest_ff, oldest_in;
   logic [AW-1:0]  wp_ff, wp_in, sptr_ff, sptr_in, snext_ff, snext_in;
   logic [AW-1:0]  addr_ff, addr_in, base_ff, base_in;
   logic [AW-1:0]  srec_ff, srec_in, count_ff, count_in;
   logic [11:0]    remain_ff, remain_in, open_len_ff, open_len_in;
   logic           open_ff, open_in, unlim_ff, unlim_in;
   logic [CW-1:0]  sleft_ff, sleft_in;
   scan_state_type sstate_ff, sstate_in;
   logic [WB-1:0]  word_ff, word_in;
   logic [IW-1:0]  idx_ff, idx_in;
   logic [1:0]     st_ff, st_in;
   logic [7:0]     rb_ff, rb_in;
   logic           bv_ff, bv_in, re_ff, re_in, sd_ff, sd_in;
   rlrb_rsp_type   rsp_ff, rsp_in;
   logic           rsp_valid_ff, rsp_valid_in;

   logic [7:0]     mem [BUFFER_BYTES];
   logic [7:0]     mem_q_ff;
   logic [MW-1:0]  mem_addr;
   logic [7:0]     mem_wdata;
   logic           mem_we, mem_re;

   logic [WB-1:0]  hdr_word;
   logic [7:0]     hdr_byte;
   logic [CW-1:0]  word_c;
   logic [AW-1:0]  walk_t, bwd_start, last_ne, last_ov;
   logic           fwd, rec_end;
   logic [CW-1:0]  left_dec;

   assign hdr_word = WB'(open_len_ff);
   assign hdr_byte = hdr_word[8*idx_ff +: 8];
   assign word_c   = CW'(word_ff);
   assign walk_t   = addr_ff - WA;
   assign bwd_start = snext_ff - word_ff[AW-1:0];
   assign fwd      = (sstate_ff == SCAN_FWD);
   assign left_dec = sleft_ff - CW'(1);
   assign rec_end  = (left_dec == '0);

   always_comb begin
      status.mode        = req_ff.mode;
      status.too_long    = (AW'(req_ff.record_length) + W2A > B1) ||
                           (W < 2 && req_ff.record_length > 12'd255);
      status.open        = open_ff;
      status.remain_one  = (remain_ff == 12'd1);
      status.len_zero    = (open_len_ff == '0);
      status.idx_last    = (idx_ff == IDX_LAST);
      status.walk_room   = (addr_ff >= oldest_ff) && (addr_ff - oldest_ff >= WA);
      status.walk_bad    = !((walk_t >= oldest_ff) && (walk_t - oldest_ff >= WA)) ||
                           (CW'(walk_t - WA - oldest_ff) < word_c);
      status.walk_limit  = (req_ff.max_records != '0) &&
                           (count_ff + AW'(1) == AW'(req_ff.max_records));
      status.sstate      = sstate_ff;
      status.fresh       = (sleft_ff == '0);
      status.srec_zero   = (srec_ff == '0);
      status.bwd_blocked = (!unlim_ff && srec_ff == '0) || (snext_ff < oldest_ff);
      status.bwd_bad     = (CW'(snext_ff - oldest_ff) < word_c);
      status.left_zero   = (sleft_ff == '0);
      status.rsp_free    = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      mem_addr  = slot_of(sptr_ff);
      mem_wdata = hdr_byte;
      mem_we    = 1'b0;
      mem_re    = 1'b0;
      unique case (cmd.op)
         OP_HDR_WR: begin
            mem_addr = slot_of(newest_ff + AW'(idx_ff));
            mem_we   = 1'b1;
         end
         OP_TRL_WR: begin
            mem_addr = slot_of(wp_ff + AW'(idx_ff));
            mem_we   = 1'b1;
         end
         OP_APPEND: begin
            mem_addr  = slot_of(wp_ff);
            mem_wdata = req_ff.data_byte;
            mem_we    = 1'b1;
         end
         OP_WORD_RD: begin
            mem_addr = slot_of(base_ff + AW'(idx_ff));
            mem_re   = 1'b1;
         end
         OP_BYTE_RD: mem_re = 1'b1;
         default: mem_re = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_addr] <= mem_wdata;
      if (mem_re) mem_q_ff <= mem[mem_addr];
   end

   always_comb begin
      req_in       = req_ff;
      newest_in    = newest_ff;
      oldest_in    = oldest_ff;
      wp_in        = wp_ff;
      sptr_in      = sptr_ff;
      snext_in     = snext_ff;
      addr_in      = addr_ff;
      base_in      = base_ff;
      srec_in      = srec_ff;
      count_in     = count_ff;
      remain_in    = remain_ff;
      open_len_in  = open_len_ff;
      open_in      = open_ff;
      unlim_in     = unlim_ff;
      sleft_in     = sleft_ff;
      sstate_in    = sstate_ff;
      word_in      = word_ff;
      idx_in       = idx_ff;
      st_in        = st_ff;
      rb_in        = rb_ff;
      bv_in        = bv_ff;
      re_in        = re_ff;
      sd_in        = sd_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      last_ne      = wp_ff + WA;
      last_ov      = raise_low(last_ne, oldest_ff);
      unique case (cmd.op)
         OP_LOAD: begin
            req_in = req_payload;
            st_in  = ST_OK;
            rb_in  = '0;
            bv_in  = 1'b0;
            re_in  = 1'b0;
            sd_in  = 1'b0;
         end
         OP_SET_ST: st_in = cmd.st;
         OP_OPEN: begin
            wp_in       = newest_ff + WA;
            remain_in   = req_ff.record_length;
            open_len_in = req_ff.record_length;
            open_in     = 1'b1;
            oldest_in   = raise_low(newest_ff + AW'(req_ff.record_length) + W2A,
                                    oldest_ff);
            idx_in      = '0;
         end
         OP_HDR_WR, OP_TRL_WR, OP_WORD_CAP: begin
            if (cmd.op == OP_WORD_CAP) word_in[8*idx_ff +: 8] = mem_q_ff;
            idx_in = (idx_ff == IDX_LAST) ? '0 : idx_ff + IW'(1);
         end
         OP_COMMIT: begin
            open_in = 1'b0;
            if (last_ne > B3) begin
               newest_in = last_ne - B1;
               oldest_in = last_ov - B1;
            end else begin
               newest_in = last_ne;
               oldest_in = last_ov;
            end
         end
         OP_APPEND: begin
            wp_in     = wp_ff + AW'(1);
            remain_in = remain_ff - 12'd1;
            idx_in    = '0;
         end
         OP_CLEAR: begin
            newest_in = B2;
            oldest_in = B2;
            open_in   = 1'b0;
            remain_in = '0;
            sstate_in = SCAN_IDLE;
            sleft_in  = '0;
         end
         OP_WALK_INIT: begin
            addr_in  = newest_ff;
            count_in = '0;
         end
         OP_WALK_STEP: begin
            addr_in  = addr_ff - W2A - word_ff[AW-1:0];
            count_in = count_ff + AW'(1);
         end
         OP_WALK_END: begin
            sptr_in   = addr_ff;
            srec_in   = count_ff;
            sleft_in  = '0;
            unlim_in  = 1'b0;
            sstate_in = SCAN_FWD;
         end
         OP_BWD_INIT: begin
            snext_in  = newest_ff - WA;
            srec_in   = AW'(req_ff.max_records);
            unlim_in  = (req_ff.max_records == '0);
            sleft_in  = '0;
            sstate_in = SCAN_BWD;
         end
         OP_WORD_START: begin
            idx_in  = '0;
            word_in = '0;
            unique case (cmd.base)
               BASE_SPTR:  base_in = sptr_ff;
               BASE_SNEXT: base_in = snext_ff;
               default:    base_in = walk_t;
            endcase
         end
         OP_FWD_HDR: begin
            sleft_in = word_c;
            sptr_in  = sptr_ff + WA;
            srec_in  = srec_ff - AW'(1);
         end
         OP_BWD_HDR: begin
            sptr_in  = bwd_start;
            sleft_in = word_c;
            snext_in = (bwd_start >= oldest_ff && bwd_start - oldest_ff >= W2A) ?
                       bwd_start - W2A : '0;
            if (!unlim_ff) srec_in = srec_ff - AW'(1);
         end
         OP_BYTE_TAKE: begin
            rb_in    = mem_q_ff;
            bv_in    = 1'b1;
            re_in    = rec_end;
            sleft_in = left_dec;
            sptr_in  = sptr_ff + AW'(1) + ((rec_end && fwd) ? WA : '0);
            if (rec_end && srec_ff == '0 && (fwd || !unlim_ff)) begin
               sd_in     = 1'b1;
               sstate_in = SCAN_DONE;
            end
         end
         OP_EMPTY_REC: begin
            re_in   = 1'b1;
            sptr_in = sptr_ff + (fwd ? WA : '0);
            if (srec_ff == '0 && (fwd || !unlim_ff)) begin
               sd_in     = 1'b1;
               sstate_in = SCAN_DONE;
            end
         end
         OP_SET_DONE: begin
            sd_in     = 1'b1;
            sstate_in = SCAN_DONE;
         end
         OP_SD_ONLY: sd_in = 1'b1;
         OP_RSP_LOAD: begin
            rsp_in.status     = st_ff;
            rsp_in.read_byte  = rb_ff;
            rsp_in.byte_valid = bv_ff;
            rsp_in.record_end = re_ff;
            rsp_in.scan_done  = sd_ff;
            rsp_in.is_empty   = (newest_ff == oldest_ff);
            rsp_valid_in      = 1'b1;
         end
         default: rsp_in = rsp_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      addr_ff     <= addr_in;
      base_ff     <= base_in;
      count_ff    <= count_in;
      open_len_ff <= open_len_in;
      word_ff     <= word_in;
      st_ff       <= st_in;
      rb_ff       <= rb_in;
      bv_ff       <= bv_in;
      re_ff       <= re_in;
      sd_ff       <= sd_in;
      rsp_ff      <= rsp_in;
      if (reset) begin
         newest_ff    <= B2;
         oldest_ff    <= B2;
         wp_ff        <= '0;
         sptr_ff      <= '0;
         snext_ff     <= '0;
         srec_ff      <= '0;
         remain_ff    <= '0;
         open_ff      <= 1'b0;
         unlim_ff     <= 1'b0;
         sleft_ff     <= '0;
         sstate_ff    <= SCAN_IDLE;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         newest_ff    <= newest_in;
         oldest_ff    <= oldest_in;
         wp_ff        <= wp_in;
         sptr_ff      <= sptr_in;
         snext_ff     <= snext_in;
         srec_ff      <= srec_in;
         remain_ff    <= remain_in;
         open_ff      <= open_in;
         unlim_ff     <= unlim_in;
         sleft_ff     <= sleft_in;
         sstate_ff    <= sstate_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_low_water_below_newest: assert property (@(posedge clock) disable iff (reset)
      oldest_ff <= newest_ff)
      else $error("low-water address above newest address");

   a_newest_rebased: assert property (@(posedge clock) disable iff (reset)
      newest_ff <= B3)
      else $error("newest address not rebased");

   a_no_pending_bytes_when_closed: assert property (@(posedge clock) disable iff (reset)
      !open_ff |-> remain_ff == '0)
      else $error("bytes pending with no open record");

   a_byte_only_on_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.byte_valid |-> rsp_ff.status == ST_OK)
      else $error("scanned byte with bad status");

endmodule
`default_nettype wire

FILE: design/record_log_ring_buffer_core.sv
`default_nettype none
// Channel   Direction  Handshake              Payload
// req       in         req_valid / req_ready  rlrb_req_type (mode, length, byte, count)
// rsp       out        rsp_valid / rsp_ready  rlrb_rsp_type (status, byte and flags)
//
// One item is in work at a time; the single-port byte store does one access per cycle.
// Append writes one byte, plus the length trailer when it completes a record; open
// writes the length header, and also the trailer for an empty record. Clear and
// backward scan start only set pointers. A read first fetches a length word when it
// starts a new record; a forward scan start reads one per record it walks back over.
// Reset is synchronous and leaves the buffer empty; a held result stalls the next result and further requests.
module record_log_ring_buffer_core #(
   parameter int BUFFER_BYTES      = 4096,
   parameter int LENGTH_WORD_BYTES = 4
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire rlrb_pkg::rlrb_req_type req_payload,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output rlrb_pkg::rlrb_rsp_type       rsp_payload
);
   import rlrb_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   rlrb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   rlrb_datapath #(
      .BUFFER_BYTES      (BUFFER_BYTES),
      .LENGTH_WORD_BYTES (LENGTH_WORD_BYTES)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .status      (status),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule
`default_nettype wire

FILE: tb/sv/rlrb_checker.sv
`timescale 1ns / 1ps
module rlrb_checker (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   input  wire logic                   req_ready,
   input  wire rlrb_pkg::rlrb_req_type req_payload,
   input  wire logic                   rsp_valid,
   input  wire logic                   rsp_ready,
   input  wire rlrb_pkg::rlrb_rsp_type rsp_payload,
   output int                          failures,
   output int                          pending,
   output int                          checked,
   output int                          bytes_read
);
   import rlrb_pkg::*;

   localparam longint unsigned BUF = 4096;
   localparam longint unsigned WB  = 4;

   logic [7:0]      log_mem [0:4095];
   longint unsigned newest_addr;
   longint unsigned low_water;
   longint unsigned wr_addr;
   longint unsigned fill_left;
   logic            filling;
   longint unsigned rd_addr;
   longint unsigned rd_left;
   longint unsigned recs_left;
   scan_state_type  walk_state;
   longint unsigned bwd_trailer;
   logic            no_limit;
   rlrb_rsp_type    expected_rsps [$];

   function automatic void store_word(longint unsigned a, longint unsigned v);
      for (int i = 0; i < WB; i++) log_mem[(a + i) % BUF] = v[8*i +: 8];
   endfunction

   function automatic longint unsigned load_word(longint unsigned a);
      longint unsigned v;
      v = 0;
      for (int i = 0; i < WB; i++) v |= longint'(log_mem[(a + i) % BUF]) << (8 * i);
      return v;
   endfunction

   function automatic logic fits_above_low(longint unsigned p, longint unsigned k);
      return p >= low_water && p - low_water >= k;
   endfunction

   function automatic void lift_low_water(longint unsigned e);
      if (e >= BUF && low_water < e - BUF) low_water = e - BUF;
   endfunction

   function automatic void close_record();
      store_word(wr_addr, 0);
      newest_addr = wr_addr + WB;
      filling = 1'b0;
      lift_low_water(newest_addr);
      if (newest_addr > 3 * BUF) begin
         newest_addr -= BUF;
         low_water -= BUF;
      end
   endfunction

   function automatic void clear_log();
      for (int i = 0; i < BUF; i++) log_mem[i] = 8'h00;
      newest_addr = 2 * BUF;
      low_water = 2 * BUF;
      wr_addr = 0;
      fill_left = 0;
      filling = 1'b0;
      rd_addr = 0;
      rd_left = 0;
      recs_left = 0;
      walk_state = SCAN_IDLE;
      bwd_trailer = 0;
      no_limit = 1'b0;
   endfunction

   function automatic rlrb_rsp_type log_step(rlrb_req_type r);
      rlrb_rsp_type    o;
      longint unsigned len, a, t, cnt, p, total, start;
      logic            fwd, ended;
      o = '0;
      len = r.record_length;
      case (r.mode)
         MODE_OPEN: begin
            if (len + 2 * WB > BUF) begin
               o.status = ST_TOO_LONG;
            end else begin
               store_word(newest_addr, len);
               wr_addr = newest_addr + WB;
               fill_left = len;
               filling = 1'b1;
               lift_low_water(newest_addr + len + 2 * WB);
               if (len == 0) close_record();
            end
         end
         MODE_APPEND: begin
            if (!filling) begin
               o.status = ST_NO_RECORD;
            end else begin
               log_mem[wr_addr % BUF] = r.data_byte;
               wr_addr++;
               fill_left--;
               if (fill_left == 0) begin
                  total = wr_addr - newest_addr - WB;
                  close_record();
                  store_word(newest_addr - WB, total);
               end
            end
         end
         MODE_CLEAR: begin
            newest_addr = 2 * BUF;
            low_water = newest_addr;
            filling = 1'b0;
            fill_left = 0;
            walk_state = SCAN_IDLE;
            rd_left = 0;
         end
         MODE_FWD: begin
            a = newest_addr;
            cnt = 0;
            forever begin
               if (!fits_above_low(a, WB)) break;
               t = a - WB;
               len = load_word(t);
               if (!fits_above_low(t, WB) || t - WB - low_water < len) break;
               a = t - WB - len;
               cnt++;
               if (r.max_records != 0 && cnt == r.max_records) break;
            end
            rd_addr = a;
            recs_left = cnt;
            rd_left = 0;
            no_limit = 1'b0;
            walk_state = SCAN_FWD;
         end
         MODE_BWD: begin
            bwd_trailer = newest_addr - WB;
            recs_left = r.max_records;
            no_limit = (r.max_records == 0);
            rd_left = 0;
            walk_state = SCAN_BWD;
         end
         MODE_READ: begin
            if (walk_state == SCAN_IDLE) begin
               o.status = ST_NO_SCAN;
            end else if (walk_state == SCAN_DONE) begin
               o.scan_done = 1'b1;
            end else begin
               fwd = (walk_state == SCAN_FWD);
               ended = 1'b0;
               if (rd_left == 0) begin
                  if (fwd) begin
                     if (recs_left == 0) begin
                        ended = 1'b1;
                     end else begin
                        rd_left = load_word(rd_addr);
                        rd_addr += WB;
                        recs_left--;
                     end
                  end else begin
                     p = bwd_trailer;
                     if ((!no_limit && recs_left == 0) || !fits_above_low(p, 0)) begin
                        ended = 1'b1;
                     end else begin
                        len = load_word(p);
                        if (p - low_water < len) begin
                           ended = 1'b1;
                        end else begin
                           start = p - len;
                           rd_addr = start;
                           rd_left = len;
                           bwd_trailer = fits_above_low(start, 2 * WB) ? start - 2 * WB : 0;
                           if (!no_limit) recs_left--;
                        end
                     end
                  end
               end
               if (ended) begin
                  o.scan_done = 1'b1;
                  walk_state = SCAN_DONE;
               end else begin
                  if (rd_left == 0) begin
                     o.record_end = 1'b1;
                  end else begin
                     o.read_byte = log_mem[rd_addr % BUF];
                     o.byte_valid = 1'b1;
                     rd_addr++;
                     rd_left--;
                     if (rd_left == 0) o.record_end = 1'b1;
                  end
                  if (o.record_end && fwd) rd_addr += WB;
                  if (o.record_end && recs_left == 0 && (fwd || !no_limit)) begin
                     o.scan_done = 1'b1;
                     walk_state = SCAN_DONE;
                  end
               end
            end
         end
         default: ;
      endcase
      o.is_empty = (newest_addr == low_water);
      return o;
   endfunction

   assign pending = expected_rsps.size();

   initial begin
      failures = 0;
      checked = 0;
      bytes_read = 0;
      clear_log();
   end

   always @(posedge clock) begin
      rlrb_rsp_type want;
      if (reset) begin
         clear_log();
         expected_rsps.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual %h", $time, rsp_payload);
               failures++;
            end else begin
               want = expected_rsps.pop_front();
               checked++;
               if (rsp_payload.byte_valid) bytes_read++;
               if (rsp_payload.status !== want.status ||
                   rsp_payload.read_byte !== want.read_byte ||
                   rsp_payload.byte_valid !== want.byte_valid ||
                   rsp_payload.record_end !== want.record_end ||
                   rsp_payload.scan_done !== want.scan_done ||
                   rsp_payload.is_empty !== want.is_empty) begin
                  $display("%0t: result mismatch, expected %h, actual %h",
                           $time, want, rsp_payload);
                  failures++;
               end
            end
         end
         if (req_valid && req_ready) expected_rsps.push_back(log_step(req_payload));
      end
   end

endmodule

FILE: tb/sv/tb_record_log_ring_buffer_core.sv
`timescale 1ns / 1ps
module tb_record_log_ring_buffer_core;
   import rlrb_pkg::*;

   localparam int ITEM_TARGET = 1250;
   localparam int CYCLE_LIMIT = 3000000;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_ready;
   rlrb_req_type req_payload;
   logic         rsp_valid;
   logic         rsp_ready;
   rlrb_rsp_type rsp_payload;
   int           failures, pending, checked, bytes_read;
   int           sent;
   int           cycles;
   logic         calm;
   logic         hold;

   record_log_ring_buffer_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload)
   );

   rlrb_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload),
      .failures(failures), .pending(pending), .checked(checked), .bytes_read(bytes_read)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (hold) rsp_ready <= 1'b0;
      else if (calm) rsp_ready <= 1'b1;
      else rsp_ready <= ($urandom_range(99) >= 13);
   end

   // The receiver stops for a long stretch so that the block backs up its input.
   initial begin
      hold = 1'b0;
      wait (sent >= 300);
      @(posedge clock);
      hold = 1'b1;
      repeat (400) @(posedge clock);
      hold = 1'b0;
   end

   initial begin
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("FAILURE");
      $finish;
   end

   task automatic send_item(logic [2:0] mode, logic [11:0] len, logic [7:0] db,
                            logic [9:0] mr);
      rlrb_req_type r;
      r.mode = mode;
      r.record_length = len;
      r.data_byte = db;
      r.max_records = mr;
      if (!calm && $urandom_range(99) < 13) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (!req_ready);
      sent++;
   endtask

   task automatic send_mode(logic [2:0] mode);
      send_item(mode, 12'($urandom), 8'($urandom), 10'($urandom));
   endtask

   task automatic send_record(int len, logic partial);
      int stop;
      stop = partial ? $urandom_range(0, len) : len;
      send_item(MODE_OPEN, 12'(len), 8'($urandom), 10'($urandom));
      for (int i = 0; i < stop; i++) begin
         if ($urandom_range(99) < 3) send_item(3'($urandom_range(0, 7)),
                                               12'($urandom_range(0, 4095)),
                                               8'($urandom), 10'($urandom));
         send_item(MODE_APPEND, 12'($urandom), 8'($urandom), 10'($urandom));
      end
   endtask

   task automatic send_scan(logic [2:0] mode, logic [9:0] mr, int reads);
      send_item(mode, 12'($urandom), 8'($urandom), mr);
      repeat (reads) send_mode(MODE_READ);
   endtask

   initial begin
      int pick, len;
      logic [9:0] mr;
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      rsp_ready = 1'b0;
      sent = 0;
      calm = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_mode(MODE_READ);
      send_item(MODE_APPEND, 12'hfff, 8'hff, 10'h3ff);
      send_item(MODE_OPEN, 12'd4095, 8'h00, 10'h000);
      send_item(MODE_OPEN, 12'd4089, 8'h00, 10'h000);
      send_item(MODE_OPEN, 12'd0, 8'h00, 10'h000);
      send_item(MODE_OPEN, 12'd3, 8'h00, 10'h000);
      send_item(MODE_APPEND, 12'd0, 8'hff, 10'h000);
      send_item(MODE_APPEND, 12'd0, 8'h00, 10'h000);
      send_item(MODE_APPEND, 12'd0, 8'haa, 10'h000);
      send_item(MODE_OPEN, 12'd5, 8'h00, 10'h000);
      send_item(MODE_APPEND, 12'd0, 8'h55, 10'h000);
      send_item(MODE_OPEN, 12'd1, 8'h00, 10'h000);
      send_item(MODE_APPEND, 12'd0, 8'h81, 10'h000);
      send_scan(MODE_FWD, 10'd0, 6);
      send_scan(MODE_BWD, 10'd1, 3);
      send_item(3'd6, 12'hfff, 8'hff, 10'h3ff);
      send_item(3'd7, 12'h000, 8'h00, 10'h000);
      send_scan(MODE_BWD, 10'h3ff, 3);
      send_mode(MODE_CLEAR);
      send_mode(MODE_READ);
      send_item(MODE_OPEN, 12'd4088, 8'h00, 10'h000);
      send_mode(MODE_CLEAR);

      while (sent < ITEM_TARGET) begin
         calm = (sent >= 700 && sent < 900);
         pick = $urandom_range(99);
         if (pick < 48) begin
            len = ($urandom_range(99) < 90) ? $urandom_range(0, 24) : $urandom_range(25, 200);
            if ($urandom_range(99) < 3) len = $urandom_range(4089, 4095);
            send_record(len, $urandom_range(99) < 6);
         end else if (pick < 72) begin
            mr = ($urandom_range(99) < 80) ? 10'($urandom_range(0, 4)) : 10'($urandom);
            send_scan(($urandom_range(1) != 0) ? MODE_FWD : MODE_BWD, mr,
                      $urandom_range(1, 60));
         end else if (pick < 74) begin
            send_mode(MODE_CLEAR);
         end else begin
            send_item(3'($urandom_range(0, 7)), 12'($urandom_range(0, 4095)),
                      8'($urandom), 10'($urandom));
         end
      end
      calm = 1'b0;
      req_valid <= 1'b0;

      while (pending != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      $display("Run covered %0d items with %0d results checked and %0d payload bytes read.",
               sent, checked, bytes_read);
      $display("Records, scans both ways, clears, rejects and stray items were mixed in.");
      if (failures == 0 && pending == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
